// ===== src/ir_pulse_width_frame_transmitter_unit_defines.svh =====
// Assertion helpers for the IR frame transmitter.
`ifndef IR_PULSE_WIDTH_FRAME_TRANSMITTER_UNIT_DEFINES_SVH
`define IR_PULSE_WIDTH_FRAME_TRANSMITTER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define IRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("irt assertion failed");

// Check that cons holds in the cycle after ante.
`define IRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("irt assertion failed");

`endif

// ===== src/irpwft_pkg.sv =====
`timescale 1ns / 1ps

package irpwft_pkg;

	localparam int FRAME_BITS = 16;
	localparam int BIT_CNT_W  = $clog2(FRAME_BITS + 1);

	localparam int DATA_W  = 16;
	localparam int HALF_W  = 8;
	localparam int CYC_W   = 8;
	localparam int GAP_W   = 12;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [HALF_W-1:0] RST_CARRIER_HALF = 8'd15;
	localparam logic [CYC_W-1:0]  RST_START_CYC    = 8'd52;
	localparam logic [CYC_W-1:0]  RST_ONE_CYC      = 8'd35;
	localparam logic [CYC_W-1:0]  RST_ZERO_CYC     = 8'd10;
	localparam logic [GAP_W-1:0]  RST_GAP_TICKS    = 12'd300;

	typedef enum logic [2:0] {
		REG_CARRIER_HALF = 3'd0,
		REG_START_CYC    = 3'd1,
		REG_ONE_CYC      = 3'd2,
		REG_ZERO_CYC     = 3'd3,
		REG_GAP_TICKS    = 3'd4
	} reg_idx_t;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SEND = 1'b1;

	// A zero count behaves as one.
	function automatic logic [GAP_W-1:0] at_least_one(input logic [GAP_W-1:0] v);
		return (v == '0) ? GAP_W'(1) : v;
	endfunction

endpackage

// ===== src/ir_pulse_width_frame_transmitter_unit.sv =====
`timescale 1ns / 1ps
// IR pulse-width frame transmitter.
// Input channel (in_valid/in_ready): opcode 0 is one microsecond tick, opcode 1
// asks to send frame_data, most significant bit first. A send while a frame is
// in flight is dropped. A frame is a start burst, then one burst per bit (long
// for one, short for zero); every burst is followed by a silent gap.
// Output channel (out_valid/out_ready): one beat per input beat with the pin
// levels after that item, busy_res, and frame_done on the tick ending the last gap.
// Latency: the result beat is valid the cycle after the input beat is taken.
// Throughput: one item per cycle; the state update is a single pass of counter
// decrement and compare between the state registers and the result register.
// When the receiver stalls, the result register holds its beat and the input
// is still taken if the held beat leaves in the same cycle; otherwise in_ready
// drops until it does.
// APB port: registers at byte addresses 0,4,8,12,16 (carrier half period,
// start, one and zero burst cycles, gap ticks); writes while busy are ignored.
// Reset: state goes idle, pins low, registers to their default timing,
// no result beat pending.
`include "ir_pulse_width_frame_transmitter_unit_defines.svh"

module ir_pulse_width_frame_transmitter_unit
	import irpwft_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [DATA_W-1:0]  frame_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               ir_level,
	output logic               muzzle_level,
	output logic               busy_res,
	output logic               frame_done,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	typedef enum logic [1:0] {PH_IDLE, PH_BURST, PH_GAP} phase_t;

	phase_t                phase_q, phase_d;
	logic [FRAME_BITS-1:0] shift_q, shift_d;
	logic [BIT_CNT_W-1:0]  bits_q, bits_d;
	logic [CYC_W-1:0]      cycles_q, cycles_d;
	logic [GAP_W-1:0]      tick_q, tick_d;
	logic                  carrier_q, carrier_d;
	logic                  done_d;

	logic [HALF_W-1:0] half_q;
	logic [CYC_W-1:0]  start_q, one_q, zero_q;
	logic [GAP_W-1:0]  gap_q;

	logic              out_valid_q, ir_q, busy_q, done_q;
	logic              in_fire, cfg_wr;
	logic [2:0]        cfg_idx;
	logic [GAP_W-1:0]  half_ticks, tick_dec;
	logic [CYC_W-1:0]  cycles_dec, bit_cycles;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign cfg_idx  = paddr[PADDR_W-1:2];
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;

	assign half_ticks = at_least_one(GAP_W'(half_q));
	assign tick_dec   = tick_q - GAP_W'(1);
	assign cycles_dec = cycles_q - CYC_W'(1);
	assign bit_cycles = shift_q[FRAME_BITS-1] ? one_q : zero_q;

	always_comb begin
		phase_d   = phase_q;
		shift_d   = shift_q;
		bits_d    = bits_q;
		cycles_d  = cycles_q;
		tick_d    = tick_q;
		carrier_d = carrier_q;
		done_d    = 1'b0;
		if (opcode == OP_SEND) begin
			if (phase_q == PH_IDLE) begin
				shift_d   = FRAME_BITS'(frame_data);
				bits_d    = BIT_CNT_W'(FRAME_BITS);
				phase_d   = PH_BURST;
				cycles_d  = CYC_W'(at_least_one(GAP_W'(start_q)));
				carrier_d = 1'b1;
				tick_d    = half_ticks;
			end
		end else if (phase_q == PH_BURST) begin
			tick_d = tick_dec;
			if (tick_dec == '0) begin
				if (carrier_q) begin
					carrier_d = 1'b0;
					tick_d    = half_ticks;
				end else begin
					cycles_d = cycles_dec;
					if (cycles_dec == '0) begin
						phase_d = PH_GAP;
						tick_d  = at_least_one(gap_q);
					end else begin
						carrier_d = 1'b1;
						tick_d    = half_ticks;
					end
				end
			end
		end else if (phase_q == PH_GAP) begin
			tick_d = tick_dec;
			if (tick_dec == '0) begin
				if (bits_q == '0) begin
					phase_d  = PH_IDLE;
					cycles_d = '0;
					done_d   = 1'b1;
				end else begin
					// advance to the next bit, most significant first
					shift_d   = {shift_q[FRAME_BITS-2:0], 1'b0};
					bits_d    = bits_q - BIT_CNT_W'(1);
					phase_d   = PH_BURST;
					cycles_d  = CYC_W'(at_least_one(GAP_W'(bit_cycles)));
					carrier_d = 1'b1;
					tick_d    = half_ticks;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			shift_q     <= '0;
			bits_q      <= '0;
			cycles_q    <= '0;
			tick_q      <= '0;
			carrier_q   <= 1'b0;
			out_valid_q <= 1'b0;
			ir_q        <= 1'b0;
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (in_fire) begin
				phase_q     <= phase_d;
				shift_q     <= shift_d;
				bits_q      <= bits_d;
				cycles_q    <= cycles_d;
				tick_q      <= tick_d;
				carrier_q   <= carrier_d;
				out_valid_q <= 1'b1;
				ir_q        <= carrier_d;
				busy_q      <= (phase_d != PH_IDLE);
				done_q      <= done_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q  <= RST_CARRIER_HALF;
			start_q <= RST_START_CYC;
			one_q   <= RST_ONE_CYC;
			zero_q  <= RST_ZERO_CYC;
			gap_q   <= RST_GAP_TICKS;
		end else if (cfg_wr && phase_q == PH_IDLE) begin
			case (cfg_idx)
				REG_CARRIER_HALF: half_q  <= pwdata[HALF_W-1:0];
				REG_START_CYC:    start_q <= pwdata[CYC_W-1:0];
				REG_ONE_CYC:      one_q   <= pwdata[CYC_W-1:0];
				REG_ZERO_CYC:     zero_q  <= pwdata[CYC_W-1:0];
				REG_GAP_TICKS:    gap_q   <= pwdata[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_CARRIER_HALF: prdata = PDATA_W'(half_q);
			REG_START_CYC:    prdata = PDATA_W'(start_q);
			REG_ONE_CYC:      prdata = PDATA_W'(one_q);
			REG_ZERO_CYC:     prdata = PDATA_W'(zero_q);
			REG_GAP_TICKS:    prdata = PDATA_W'(gap_q);
			default:          prdata = '0;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign ir_level     = ir_q;
	assign muzzle_level = ir_q;
	assign busy_res     = busy_q;
	assign frame_done   = done_q;

	`IRT_ASSERT_NEXT(a_fire_gives_beat, clk, arst_n, in_fire, out_valid)
	`IRT_ASSERT_NOW(a_done_not_busy, clk, arst_n, out_valid && frame_done, !busy_res)
	`IRT_ASSERT_NOW(a_idle_dark, clk, arst_n, phase_q == PH_IDLE, !carrier_q)
	`IRT_ASSERT_NOW(a_gap_dark, clk, arst_n, phase_q == PH_GAP, !carrier_q)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import irpwft_pkg::*;

	localparam int WATCHDOG_CYCLES = 4000;
	localparam int HOLDOFF_CYCLES  = 120;
	localparam int RANDOM_ITEMS    = 200;
	localparam int MAX_REPORTS     = 40;

	typedef enum logic [1:0] {TX_IDLE, TX_BURST, TX_GAP} tx_phase_t;

	typedef struct {
		logic              op;
		logic [DATA_W-1:0] data;
		int                pause;
	} beat_t;

	typedef struct packed {
		logic ir;
		logic muzzle;
		logic busy;
		logic done;
	} levels_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               opcode = OP_TICK;
	logic [DATA_W-1:0]  frame_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               ir_level;
	logic               muzzle_level;
	logic               busy_res;
	logic               frame_done;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	ir_pulse_width_frame_transmitter_unit uut (.*);

	// transmitter timing registers as the testbench expects them
	logic [HALF_W-1:0]    tx_half;
	logic [CYC_W-1:0]     tx_start;
	logic [CYC_W-1:0]     tx_one;
	logic [CYC_W-1:0]     tx_zero;
	logic [GAP_W-1:0]     tx_gap;
	// transmitter sequencing state
	tx_phase_t            tx_phase;
	logic [FRAME_BITS-1:0] tx_word;
	logic [BIT_CNT_W-1:0] tx_bits_left;
	logic [CYC_W-1:0]     tx_cycles_left;
	logic [GAP_W-1:0]     tx_ticks;
	logic                 tx_carrier;

	beat_t   pending[$];
	levels_t expected_levels[$];

	bit tx_calm = 1'b1;
	bit rx_calm = 1'b1;
	int quiet_odds = 64;
	int rx_stall = 0;
	int holdoff_at = -1;
	int quiet_cycles = 0;
	int queued_items = 0;
	int n_items = 0;
	int n_results = 0;
	int n_frames = 0;
	int n_writes = 0;
	int n_settings = 0;
	int n_bad = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [GAP_W-1:0] nonzero(input logic [GAP_W-1:0] v);
		return v + GAP_W'(v == '0);
	endfunction

	function automatic void start_burst(input logic [GAP_W-1:0] cycles);
		tx_phase = TX_BURST;
		tx_cycles_left = CYC_W'(nonzero(cycles));
		tx_carrier = 1'b1;
		tx_ticks = nonzero(GAP_W'(tx_half));
	endfunction

	function automatic levels_t tx_step(input logic op, input logic [DATA_W-1:0] data);
		logic done;
		logic bit_now;
		done = 1'b0;
		if (op == OP_SEND) begin
			if (tx_phase == TX_IDLE) begin
				tx_word = FRAME_BITS'(data);
				tx_bits_left = BIT_CNT_W'(FRAME_BITS);
				start_burst(GAP_W'(tx_start));
			end
		end else if (tx_phase == TX_BURST) begin
			tx_ticks = tx_ticks - GAP_W'(1);
			if (tx_ticks == '0) begin
				if (tx_carrier) begin
					tx_carrier = 1'b0;
					tx_ticks = nonzero(GAP_W'(tx_half));
				end else begin
					tx_cycles_left = tx_cycles_left - CYC_W'(1);
					if (tx_cycles_left == '0) begin
						tx_phase = TX_GAP;
						tx_ticks = nonzero(tx_gap);
					end else begin
						tx_carrier = 1'b1;
						tx_ticks = nonzero(GAP_W'(tx_half));
					end
				end
			end
		end else if (tx_phase == TX_GAP) begin
			tx_ticks = tx_ticks - GAP_W'(1);
			if (tx_ticks == '0) begin
				if (tx_bits_left == '0) begin
					tx_phase = TX_IDLE;
					tx_cycles_left = '0;
					done = 1'b1;
					n_frames++;
				end else begin
					// next bit, MSB first
					bit_now = tx_word[FRAME_BITS-1];
					tx_word = tx_word << 1;
					tx_bits_left = tx_bits_left - BIT_CNT_W'(1);
					start_burst(GAP_W'(bit_now ? tx_one : tx_zero));
				end
			end
		end
		return {tx_carrier, tx_carrier, tx_phase != TX_IDLE, done};
	endfunction

	// ticks from the send beat to the tick that ends the last gap
	function automatic int frame_ticks(input logic [DATA_W-1:0] data);
		logic [FRAME_BITS-1:0] word;
		int carrier;
		int total;
		word = FRAME_BITS'(data);
		carrier = 2 * int'(nonzero(GAP_W'(tx_half)));
		total = int'(nonzero(GAP_W'(tx_start))) * carrier + int'(nonzero(tx_gap));
		for (int i = 0; i < FRAME_BITS; i++)
			total += int'(nonzero(GAP_W'(word[i] ? tx_one : tx_zero))) * carrier
				+ int'(nonzero(tx_gap));
		return total;
	endfunction

	function automatic logic [PADDR_W-1:0] reg_addr(input logic [2:0] idx);
		return PADDR_W'({idx, 2'b00});
	endfunction

	function automatic void put(input logic op, input logic [DATA_W-1:0] data);
		beat_t b;
		b.op = op;
		b.data = data;
		b.pause = tx_calm ? 0 : $urandom_range(0, 6);
		pending.push_back(b);
		queued_items++;
		if ($urandom_range(0, tx_calm ? quiet_odds : 15) == 0)
			tx_calm = !tx_calm;
	endfunction

	// send, then exactly the ticks of the frame; stray sends land only while busy
	function automatic void queue_frame(input logic [DATA_W-1:0] data, input int stray_pct);
		int n;
		n = frame_ticks(data);
		put(OP_SEND, data);
		for (int i = 0; i < n; i++) begin
			put(OP_TICK, DATA_W'($urandom));
			if (i < n - 1 && $urandom_range(0, 99) < stray_pct)
				put(OP_SEND, DATA_W'($urandom));
		end
	endfunction

	task automatic check_bit(input string what, input logic want, input logic got);
		if (want !== got) begin
			n_bad++;
			if (n_bad <= MAX_REPORTS)
				$display("%0t ns: %s expected %0b got %0b", $time, what, want, got);
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending.size() != 0 || in_valid || expected_levels.size() != 0);
		repeat (2) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// writes during a frame are dropped
		if (tx_phase == TX_IDLE) begin
			case (addr[PADDR_W-1:2])
				REG_CARRIER_HALF: tx_half  = value[HALF_W-1:0];
				REG_START_CYC:    tx_start = value[CYC_W-1:0];
				REG_ONE_CYC:      tx_one   = value[CYC_W-1:0];
				REG_ZERO_CYC:     tx_zero  = value[CYC_W-1:0];
				REG_GAP_TICKS:    tx_gap   = value[GAP_W-1:0];
				default: ;
			endcase
		end
		n_writes++;
		@(negedge clk);
	endtask

	task automatic check_regs();
		logic [PDATA_W-1:0] want;
		for (int i = REG_CARRIER_HALF; i <= REG_GAP_TICKS; i++) begin
			case (i)
				REG_CARRIER_HALF: want = PDATA_W'(tx_half);
				REG_START_CYC:    want = PDATA_W'(tx_start);
				REG_ONE_CYC:      want = PDATA_W'(tx_one);
				REG_ZERO_CYC:     want = PDATA_W'(tx_zero);
				default:          want = PDATA_W'(tx_gap);
			endcase
			@(posedge clk);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= reg_addr(3'(i));
			@(posedge clk);
			penable <= 1'b1;
			@(negedge clk);
			if (prdata !== want) begin
				n_bad++;
				if (n_bad <= MAX_REPORTS)
					$display("%0t ns: register %0d expected %0h got %0h", $time, i, want, prdata);
			end
			@(posedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
		end
		@(negedge clk);
	endtask

	// upper pwdata bits carry junk that the register must drop
	task automatic set_timing(input int half, input int start, input int one, input int zero,
			input int gap);
		wait_idle();
		cfg_write(reg_addr(REG_CARRIER_HALF), ($urandom << HALF_W) | PDATA_W'(half));
		cfg_write(reg_addr(REG_START_CYC), ($urandom << CYC_W) | PDATA_W'(start));
		cfg_write(reg_addr(REG_ONE_CYC), ($urandom << CYC_W) | PDATA_W'(one));
		cfg_write(reg_addr(REG_ZERO_CYC), ($urandom << CYC_W) | PDATA_W'(zero));
		cfg_write(reg_addr(REG_GAP_TICKS), ($urandom << GAP_W) | PDATA_W'(gap));
		check_regs();
		n_settings++;
	endtask

	// sender: accept, predict, then present the next beat after its pause
	always @(posedge clk) begin
		beat_t cur;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_levels.push_back(tx_step(opcode, frame_data));
				n_items++;
			end
			if (!in_valid || in_ready) begin
				if (pending.size() == 0) begin
					in_valid <= 1'b0;
				end else if (pending[0].pause > 0) begin
					pending[0].pause = pending[0].pause - 1;
					in_valid <= 1'b0;
				end else begin
					cur = pending.pop_front();
					in_valid <= 1'b1;
					opcode <= cur.op;
					frame_data <= cur.data;
				end
			end
		end
	end

	// receiver: check each beat, then stall for a drawn number of cycles
	always @(posedge clk) begin
		levels_t got;
		levels_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = {ir_level, muzzle_level, busy_res, frame_done};
				if (expected_levels.size() == 0) begin
					n_bad++;
					if (n_bad <= MAX_REPORTS)
						$display("%0t ns: unexpected result beat %b", $time, got);
				end else begin
					want = expected_levels.pop_front();
					check_bit("ir_level", want.ir, got.ir);
					check_bit("muzzle_level", want.muzzle, got.muzzle);
					check_bit("busy_res", want.busy, got.busy);
					check_bit("frame_done", want.done, got.done);
				end
				n_results++;
				if (n_results == holdoff_at)
					rx_stall = HOLDOFF_CYCLES;
				else
					rx_stall = rx_calm ? 0 : $urandom_range(0, 6);
				if ($urandom_range(0, rx_calm ? 31 : 15) == 0)
					rx_calm = !rx_calm;
			end else if (rx_stall > 0) begin
				rx_stall--;
			end
			out_ready <= (rx_stall == 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || psel || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("%0t ns: no beat moved for %0d cycles", $time, quiet_cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int n;
		int first;
		int random_items;
		random_items = 0;
		tx_half = RST_CARRIER_HALF;
		tx_start = RST_START_CYC;
		tx_one = RST_ONE_CYC;
		tx_zero = RST_ZERO_CYC;
		tx_gap = RST_GAP_TICKS;
		tx_phase = TX_IDLE;
		tx_word = '0;
		tx_bits_left = '0;
		tx_cycles_left = '0;
		tx_ticks = '0;
		tx_carrier = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		check_regs();

		// ticks while idle
		repeat (3) put(OP_TICK, DATA_W'($urandom));

		set_timing(1, 1, 2, 1, 1);
		put(OP_SEND, 16'hFFFF);
		put(OP_SEND, 16'h0000);
		repeat (frame_ticks(16'hFFFF)) put(OP_TICK, DATA_W'($urandom));
		queue_frame(16'h8001, 0);
		queue_frame(16'h7FFE, 20);

		// register writes in the middle of a frame must not take
		put(OP_SEND, 16'h5A3C);
		n = frame_ticks(16'h5A3C);
		repeat (n / 2) put(OP_TICK, DATA_W'($urandom));
		wait_idle();
		cfg_write(reg_addr(REG_GAP_TICKS), 32'd9);
		cfg_write(reg_addr(REG_CARRIER_HALF), 32'd3);
		check_regs();
		repeat (n - n / 2) put(OP_TICK, DATA_W'($urandom));
		wait_idle();
		cfg_write(5'd20, 32'hFFFF_FFFF);

		// zero counts behave as one
		set_timing(0, 0, 0, 0, 0);
		queue_frame(DATA_W'($urandom), 0);

		// register maxima, read back only
		set_timing(255, 255, 255, 255, 4095);

		quiet_odds = 8;
		while (random_items < RANDOM_ITEMS || holdoff_at < 0) begin
			set_timing($urandom_range(0, 2), $urandom_range(0, 3), $urandom_range(0, 3),
				$urandom_range(0, 3), $urandom_range(0, 4));
			first = queued_items;
			repeat (2) begin
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 4)) put(OP_TICK, DATA_W'($urandom));
				else
					queue_frame(DATA_W'($urandom), 8);
			end
			// hold off the receiver once while plenty of beats are queued
			if (holdoff_at < 0 && queued_items - first > 60)
				holdoff_at = n_results + 20;
			wait_idle();
			random_items += queued_items - first;
		end

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Checked %0d result beats for %0d input beats; %0d frames ran to completion.",
			n_results, n_items, n_frames);
		$display("Timing reprogrammed %0d times with %0d register writes, zeros and maxima included.",
			n_settings, n_writes);
		if (n_bad == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== ir_pulse_width_frame_transmitter_unit.f =====
+incdir+src
src/irpwft_pkg.sv
src/ir_pulse_width_frame_transmitter_unit.sv
tb/tb.sv
